/* rtl/gjdc_pkg.sv */
// ----------------------------------------------------------------------------
// gjdc_pkg
// Shared constants and small helper functions for the Gregorian date and
// Julian Day Number converter.
// ----------------------------------------------------------------------------
package gjdc_pkg;

    localparam int ENC_STAGES = 2;
    localparam int DEC_STAGES = 8;
    localparam int NUM_STAGES = ENC_STAGES + DEC_STAGES;

    localparam logic [22:0] JDN_MIN = 23'd1721060;
    localparam logic [22:0] JDN_MAX = 23'd5373484;

    localparam logic       FUNC_DATE_TO_JDN = 1'b0;
    localparam logic       FUNC_JDN_TO_DATE = 1'b1;

    // days from 1 march to the start of month m, months counted from march
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd428;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

    // remainder by seven, using 8 = 1 mod 7 on octal digits
    function automatic logic [2:0] mod7(input logic [23:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        int         i;
        s1 = 6'd0;
        for (i = 0; i < 8; i++) begin
            s1 = s1 + {3'b000, x[3*i +: 3]};
        end
        s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
        if (s2 >= 4'd14) begin
            r = s2 - 4'd14;
        end else if (s2 >= 4'd7) begin
            r = s2 - 4'd7;
        end else begin
            r = s2;
        end
        return r[2:0];
    endfunction

endpackage

/* rtl/gjdc_encode.sv */
// ----------------------------------------------------------------------------
// gjdc_encode
// Two pipeline stages: date to day number, or pass-through of the given
// day number, selected by func.
// ----------------------------------------------------------------------------
module gjdc_encode (
    input  logic        aclk,
    input  logic [1:0]  en,
    input  logic        func,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [22:0] day_number,
    output logic [22:0] jdn
);

    localparam logic [14:0] YEAR_BIAS  = 15'd4800;
    localparam logic [24:0] JDN_BIAS   = 25'd32045;
    localparam logic [25:0] RECIP_25   = 26'd5243;

    // stage 1
    logic        func_reg;
    logic [22:0] dn_reg;
    logic [4:0]  day_reg;
    logic [8:0]  ofs_reg;
    logic [23:0] y365_reg;
    logic [12:0] y4_reg;
    logic [25:0] p100_reg;

    logic        early;
    logic [14:0] y_next;
    logic [3:0]  midx;
    logic [8:0]  ofs_next;
    logic [23:0] y365_next;
    logic [25:0] p100_next;

    always_comb begin
        early     = (month <= 4'd2);
        y_next    = 15'(year) + YEAR_BIAS - 15'(early);
        midx      = early ? (month + 4'd9) : (month - 4'd3);
        ofs_next  = gjdc_pkg::month_offset(midx);
        y365_next = {9'b0, y_next} * 24'd365;
        p100_next = {13'b0, y_next[14:2]} * RECIP_25;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            func_reg <= func;
            dn_reg   <= day_number;
            day_reg  <= day;
            ofs_reg  <= ofs_next;
            y365_reg <= y365_next;
            y4_reg   <= y_next[14:2];
            p100_reg <= p100_next;
        end
    end

    // stage 2
    logic [22:0] jdn_reg;
    logic [22:0] jdn_next;
    logic [8:0]  q100;
    logic [24:0] sum;

    always_comb begin
        q100 = p100_reg[25:17];
        sum  = 25'(day_reg) + 25'(ofs_reg) + 25'(y365_reg) + 25'(y4_reg)
             - 25'(q100) + 25'(q100[8:2]) - JDN_BIAS;
        jdn_next = (func_reg == gjdc_pkg::FUNC_JDN_TO_DATE) ? dn_reg : sum[22:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            jdn_reg <= jdn_next;
        end
    end

    assign jdn = jdn_reg;

endmodule

/* rtl/gjdc_decode.sv */
// ----------------------------------------------------------------------------
// gjdc_decode
// Eight pipeline stages: range check, weekday and decode of a day number
// into year, month and day by reciprocal multiplies with one-step correction.
// ----------------------------------------------------------------------------
module gjdc_decode (
    input  logic        aclk,
    input  logic [7:0]  en,
    input  logic [22:0] jdn,
    output logic [22:0] julian_day,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [2:0]  weekday,
    output logic        range_error
);

    localparam logic [23:0] DEC_BIAS   = 24'd32044;
    localparam logic [26:0] DAYS_400Y  = 27'd146097;
    localparam logic [18:0] DAYS_4Y    = 19'd1461;
    localparam logic [40:0] RECIP_400Y = 41'd29398;
    localparam logic [31:0] RECIP_4Y   = 32'd11483;
    localparam logic [24:0] RECIP_153  = 25'd6854;
    localparam logic [15:0] YEAR_BIAS  = 16'd4800;

    // day number, weekday and range flag ride along
    logic [22:0] jdn_pipe_reg [8];
    logic [2:0]  wd_pipe_reg  [8];
    logic        err_pipe_reg [8];

    logic [2:0]  wd_next;
    logic        err_next;

    // stage 0
    logic [23:0] a0_reg;
    logic [40:0] p1_reg;
    logic [23:0] a_next;
    logic [40:0] p1_next;

    always_comb begin
        err_next = (jdn < gjdc_pkg::JDN_MIN) || (jdn > gjdc_pkg::JDN_MAX);
        wd_next  = gjdc_pkg::mod7({1'b0, jdn} + 24'd1);
        a_next   = {1'b0, jdn} + DEC_BIAS;
        p1_next  = {15'b0, a_next, 2'b11} * RECIP_400Y;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            jdn_pipe_reg[0] <= jdn;
            wd_pipe_reg[0]  <= wd_next;
            err_pipe_reg[0] <= err_next;
            a0_reg          <= a_next;
            p1_reg          <= p1_next;
        end
    end

    for (genvar k = 1; k < 8; k++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                jdn_pipe_reg[k] <= jdn_pipe_reg[k-1];
                wd_pipe_reg[k]  <= wd_pipe_reg[k-1];
                err_pipe_reg[k] <= err_pipe_reg[k-1];
            end
        end
    end

    // stage 1: estimate of the 400-year count
    logic [23:0] a1_reg;
    logic [8:0]  b0_reg;
    logic [26:0] pb_reg;
    logic [26:0] pb_next;

    assign pb_next = {18'b0, p1_reg[40:32]} * DAYS_400Y;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            a1_reg <= a0_reg;
            b0_reg <= p1_reg[40:32];
            pb_reg <= pb_next;
        end
    end

    // stage 2: correct the estimate, day within the 400-year cycle
    logic [8:0]  b2_reg;
    logic [15:0] c2_reg;
    logic [26:0] rem1;
    logic        corr1;
    logic [8:0]  b_next;
    logic [26:0] pf1;
    logic [24:0] cdiff;

    always_comb begin
        rem1   = {1'b0, a1_reg, 2'b11} - pb_reg;
        corr1  = (rem1 >= DAYS_400Y);
        b_next = b0_reg + 9'(corr1);
        pf1    = pb_reg + (corr1 ? DAYS_400Y : 27'd0);
        cdiff  = {1'b0, a1_reg} - pf1[26:2];
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            b2_reg <= b_next;
            c2_reg <= cdiff[15:0];
        end
    end

    // stage 3: estimate of the 4-year count
    logic [8:0]  b3_reg;
    logic [15:0] c3_reg;
    logic [31:0] p2_reg;
    logic [31:0] p2_next;

    assign p2_next = {14'b0, c2_reg, 2'b11} * RECIP_4Y;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            b3_reg <= b2_reg;
            c3_reg <= c2_reg;
            p2_reg <= p2_next;
        end
    end

    // stage 4
    logic [8:0]  b4_reg;
    logic [15:0] c4_reg;
    logic [7:0]  d0_reg;
    logic [18:0] pd_reg;
    logic [18:0] pd_next;

    assign pd_next = {11'b0, p2_reg[31:24]} * DAYS_4Y;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            b4_reg <= b3_reg;
            c4_reg <= c3_reg;
            d0_reg <= p2_reg[31:24];
            pd_reg <= pd_next;
        end
    end

    // stage 5: correct the estimate, day within the 4-year cycle
    logic [8:0]  b5_reg;
    logic [7:0]  d5_reg;
    logic [8:0]  e5_reg;
    logic [18:0] rem2;
    logic        corr2;
    logic [18:0] pf2;
    logic [16:0] ediff;

    always_comb begin
        rem2  = {1'b0, c4_reg, 2'b11} - pd_reg;
        corr2 = (rem2 >= DAYS_4Y);
        pf2   = pd_reg + (corr2 ? DAYS_4Y : 19'd0);
        ediff = {1'b0, c4_reg} - pf2[18:2];
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            b5_reg <= b4_reg;
            d5_reg <= d0_reg + 8'(corr2);
            e5_reg <= ediff[8:0];
        end
    end

    // stage 6: month estimate
    logic [8:0]  b6_reg;
    logic [7:0]  d6_reg;
    logic [8:0]  e6_reg;
    logic [24:0] p3_reg;
    logic [11:0] n3;
    logic [24:0] p3_next;

    always_comb begin
        n3      = {3'b0, e5_reg} * 12'd5 + 12'd2;
        p3_next = {13'b0, n3} * RECIP_153;
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            b6_reg <= b5_reg;
            d6_reg <= d5_reg;
            e6_reg <= e5_reg;
            p3_reg <= p3_next;
        end
    end

    // stage 7: output register
    logic [13:0] yr_reg;
    logic [3:0]  mo_reg;
    logic [4:0]  dy_reg;
    logic [4:0]  m;
    logic        wrap;
    logic [8:0]  dy_full;
    logic [15:0] yr_full;
    logic [3:0]  mo_next;

    always_comb begin
        m       = p3_reg[24:20];
        wrap    = (m >= 5'd10);
        dy_full = e6_reg - gjdc_pkg::month_offset(m[3:0]) + 9'd1;
        mo_next = m[3:0] + 4'd3 - (wrap ? 4'd12 : 4'd0);
        yr_full = {7'b0, b6_reg} * 16'd100 + 16'(d6_reg) + 16'(wrap) - YEAR_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            if (err_pipe_reg[6]) begin
                yr_reg <= 14'd0;
                mo_reg <= 4'd0;
                dy_reg <= 5'd0;
            end else begin
                yr_reg <= yr_full[13:0];
                mo_reg <= mo_next;
                dy_reg <= dy_full[4:0];
            end
        end
    end

    assign julian_day  = jdn_pipe_reg[7];
    assign weekday     = wd_pipe_reg[7];
    assign range_error = err_pipe_reg[7];
    assign out_year    = yr_reg;
    assign out_month   = mo_reg;
    assign out_day     = dy_reg;

endmodule

/* rtl/gregorian_julian_day_converter.sv */
// Throughput: one request per cycle unless all stages are full and m_ready is low;
// ten register stages, each with its own valid bit, and each stage's ready depends
// only on its own valid bit and on the ready of the stage after it.
// A stalled result holds in the last stage while earlier stages keep filling.
// Reset (aresetn low, synchronous) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter
// Proleptic Gregorian date to Julian Day Number and back, with weekday and
// range flag, as a ten-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [13:0] s_year,
    input  logic [3:0]  s_month,
    input  logic [4:0]  s_day,
    input  logic [22:0] s_day_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [22:0] m_julian_day,
    output logic [13:0] m_out_year,
    output logic [3:0]  m_out_month,
    output logic [4:0]  m_out_day,
    output logic [2:0]  m_weekday,
    output logic        m_range_error
);

    localparam int NS = gjdc_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   en;
    logic [22:0]   jdn;

    always_comb begin
        en[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NS-1];

    gjdc_encode u_encode (
        .aclk       (aclk),
        .en         (en[gjdc_pkg::ENC_STAGES-1:0]),
        .func       (s_func),
        .year       (s_year),
        .month      (s_month),
        .day        (s_day),
        .day_number (s_day_number),
        .jdn        (jdn)
    );

    gjdc_decode u_decode (
        .aclk        (aclk),
        .en          (en[NS-1:gjdc_pkg::ENC_STAGES]),
        .jdn         (jdn),
        .julian_day  (m_julian_day),
        .out_year    (m_out_year),
        .out_month   (m_out_month),
        .out_day     (m_out_day),
        .weekday     (m_weekday),
        .range_error (m_range_error)
    );

    // flagged requests carry an all-zero date
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |->
            m_out_year == 14'd0 && m_out_month == 4'd0 && m_out_day == 5'd0)
        else $error("range error with nonzero date");

    // decoded month lies in 1 to 12
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error |-> m_out_month >= 4'd1 && m_out_month <= 4'd12)
        else $error("decoded month out of range");

    // decoded day lies in 1 to 31
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error |-> m_out_day >= 5'd1)
        else $error("decoded day is zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_weekday <= 3'd6)
        else $error("weekday out of range");

    // back-pressure only once every stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &valid_reg)
        else $error("input stalled with a free stage");

endmodule

/* bench/tb_gregorian_julian_day_converter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_julian_day_converter
// Self-checking bench for the date and day number converter. Requests go in
// through the s_ handshake, in bursts in some tests. The receiver stalls on a
// pattern of its own when stalls are on. Every accepted request is converted by
// an in-bench calendar predictor and queued. Each result leaving the m_ ports is
// checked field by field against the oldest queued conversion.
// ----------------------------------------------------------------------------
module tb_gregorian_julian_day_converter;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 3 * gjdc_pkg::NUM_STAGES;

    typedef struct packed {
        logic        func;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] day_number;
    } conv_request_t;

    typedef struct packed {
        logic [22:0] julian_day;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [2:0]  weekday;
        logic        range_error;
    } conv_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [13:0] s_year;
    logic [3:0]  s_month;
    logic [4:0]  s_day;
    logic [22:0] s_day_number;
    logic        m_valid;
    logic        m_ready;
    logic [22:0] m_julian_day;
    logic [13:0] m_out_year;
    logic [3:0]  m_out_month;
    logic [4:0]  m_out_day;
    logic [2:0]  m_weekday;
    logic        m_range_error;

    conv_result_t pending_conversions[$];
    conv_result_t oldest_conversion;
    int           errors;
    int           idle_cycles;
    int           burst_left;
    bit           tx_gaps_on;
    bit           rx_stall_on;
    logic [15:0]  rx_pattern;
    int           rx_phase;

    gregorian_julian_day_converter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_year        (s_year),
        .s_month       (s_month),
        .s_day         (s_day),
        .s_day_number  (s_day_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_julian_day  (m_julian_day),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_weekday     (m_weekday),
        .m_range_error (m_range_error)
    );

    initial begin
        aclk = 1'b0;
    end

    always #CLK_HALF aclk = ~aclk;

    // calendar predictor
    function automatic conv_result_t predict_conversion(conv_request_t rq);
        longint unsigned yr, mo, dy, y, m, jdn;
        longint unsigned a, b, c, d, e, mq, wrap;
        conv_result_t    res;
        if (rq.func == gjdc_pkg::FUNC_DATE_TO_JDN) begin
            yr  = rq.year;
            mo  = rq.month;
            dy  = rq.day;
            y   = yr + 4800 - ((mo <= 2) ? 1 : 0);
            m   = (mo <= 2) ? mo + 9 : mo - 3;
            jdn = dy + (153 * m + 2) / 5 + y * 365 + y / 4 - y / 100 + y / 400 - 32045;
        end else begin
            jdn = rq.day_number;
        end
        res             = '0;
        res.julian_day  = jdn[22:0];
        res.weekday     = 3'((jdn + 1) % 7);
        res.range_error = (jdn < gjdc_pkg::JDN_MIN) || (jdn > gjdc_pkg::JDN_MAX);
        if (!res.range_error) begin
            a             = jdn + 32044;
            b             = (4 * a + 3) / 146097;
            c             = a - (b * 146097) / 4;
            d             = (4 * c + 3) / 1461;
            e             = c - (1461 * d) / 4;
            mq            = (5 * e + 2) / 153;
            wrap          = mq / 10;
            res.out_day   = 5'(e - (153 * mq + 2) / 5 + 1);
            res.out_month = 4'(mq + 3 - 12 * wrap);
            res.out_year  = 14'(b * 100 + d + wrap - 4800);
        end
        return res;
    endfunction

    function automatic conv_request_t date_request(int yr, int mo, int dy);
        conv_request_t rq;
        rq.func       = gjdc_pkg::FUNC_DATE_TO_JDN;
        rq.year       = 14'(yr);
        rq.month      = 4'(mo);
        rq.day        = 5'(dy);
        rq.day_number = 23'($urandom);
        return rq;
    endfunction

    function automatic conv_request_t day_number_request(int unsigned n);
        conv_request_t rq;
        rq.func       = gjdc_pkg::FUNC_JDN_TO_DATE;
        rq.year       = 14'($urandom);
        rq.month      = 4'($urandom);
        rq.day        = 5'($urandom);
        rq.day_number = 23'(n);
        return rq;
    endfunction

    function automatic conv_request_t random_date_request();
        int pick;
        int yr;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return date_request($urandom_range(0, 16383), $urandom_range(0, 15),
                                $urandom_range(0, 31));
        end
        case (pick)
            2:       yr = $urandom_range(0, 3);
            3:       yr = $urandom_range(9996, 9999);
            default: yr = $urandom_range(0, 9999);
        endcase
        return date_request(yr, $urandom_range(1, 12), $urandom_range(1, 31));
    endfunction

    function automatic conv_request_t random_day_number_request();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            return day_number_request($urandom_range(gjdc_pkg::JDN_MIN, gjdc_pkg::JDN_MAX));
        end else if (pick < 14) begin
            return day_number_request($urandom_range(gjdc_pkg::JDN_MIN - 40,
                                                     gjdc_pkg::JDN_MIN + 40));
        end else if (pick < 16) begin
            return day_number_request($urandom_range(gjdc_pkg::JDN_MAX - 40,
                                                     gjdc_pkg::JDN_MAX + 40));
        end
        return day_number_request($urandom_range(0, 8388607));
    endfunction

    // one request through the s_ handshake, with a gap between bursts when gaps are on
    task automatic send_request(conv_request_t rq);
        int gap;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 20);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_func       <= rq.func;
        s_year       <= rq.year;
        s_month      <= rq.month;
        s_day        <= rq.day;
        s_day_number <= rq.day_number;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_conversions.push_back(predict_conversion(rq));
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_conversions.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed_dates();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b1;
        send_request(date_request(0, 1, 1));
        send_request(date_request(9999, 12, 31));
        send_request(date_request(0, 0, 0));
        send_request(date_request(16383, 15, 31));
        send_request(date_request(2000, 2, 29));
        send_request(date_request(1900, 2, 29));
        send_request(date_request(2023, 2, 31));
        send_request(date_request(2024, 3, 0));
        send_request(date_request(1582, 10, 15));
        send_request(date_request(2000, 1, 1));
        send_request(date_request(1999, 13, 1));
        send_request(date_request(1999, 14, 29));
        send_request(date_request(1999, 15, 31));
        send_request(date_request(2001, 0, 31));
        send_request(date_request(0, 0, 31));
    endtask

    task automatic test_directed_day_numbers();
        send_request(day_number_request(0));
        send_request(day_number_request(gjdc_pkg::JDN_MIN - 1));
        send_request(day_number_request(gjdc_pkg::JDN_MIN));
        send_request(day_number_request(gjdc_pkg::JDN_MAX));
        send_request(day_number_request(gjdc_pkg::JDN_MAX + 1));
        send_request(day_number_request(8388607));
        send_request(day_number_request(2451545));
        send_request(day_number_request(2299161));
        send_request(day_number_request(2299160));
    endtask

    task automatic test_random_dates(int count);
        for (int i = 0; i < count; i++) begin
            tx_gaps_on  = (i >= 150);
            rx_stall_on = (i >= 150);
            send_request(random_date_request());
        end
    endtask

    task automatic test_random_day_numbers(int count);
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            send_request(random_day_number_request());
        end
    endtask

    task automatic test_mixed_traffic(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                hold_until_drained();
            end
            if ($urandom_range(0, 1) == 0) begin
                send_request(random_date_request());
            end else begin
                send_request(random_day_number_request());
            end
        end
    endtask

    // receiver stall pattern, reloaded once each of its 16 bits has been used
    always @(negedge aclk) begin
        if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else begin
            if (rx_phase == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    rx_pattern = 16'h0000;
                end else if ($urandom_range(0, 3) == 0) begin
                    rx_pattern = 16'hffff;
                end else begin
                    rx_pattern = 16'($urandom);
                end
            end
            m_ready  <= rx_pattern[rx_phase];
            rx_phase = (rx_phase + 1) % 16;
        end
    end

    task automatic report_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_conversions.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual day %0d",
                         $time, m_julian_day);
                errors++;
            end else begin
                oldest_conversion = pending_conversions.pop_front();
                report_field("julian_day", oldest_conversion.julian_day, m_julian_day);
                report_field("out_year", oldest_conversion.out_year, m_out_year);
                report_field("out_month", oldest_conversion.out_month, m_out_month);
                report_field("out_day", oldest_conversion.out_day, m_out_day);
                report_field("weekday", oldest_conversion.weekday, m_weekday);
                report_field("range_error", oldest_conversion.range_error, m_range_error);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_gregorian_julian_day_converter: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = gjdc_pkg::FUNC_DATE_TO_JDN;
        s_year       = '0;
        s_month      = '0;
        s_day        = '0;
        s_day_number = '0;
        m_ready      = 1'b0;
        errors       = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        tx_gaps_on   = 1'b0;
        rx_stall_on  = 1'b0;
        rx_pattern   = '1;
        rx_phase     = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_dates();
        test_directed_day_numbers();
        test_random_dates(700);
        test_random_day_numbers(600);
        test_mixed_traffic(350);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_conversions.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_conversions.size() == 0) begin
            $display("tb_gregorian_julian_day_converter: PASS");
        end else begin
            $display("tb_gregorian_julian_day_converter: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gjdc_pkg.sv
rtl/gjdc_encode.sv
rtl/gjdc_decode.sv
rtl/gregorian_julian_day_converter.sv
bench/tb_gregorian_julian_day_converter.sv
